### hw/rtl/tapv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapv_pkg
// shared types and constants for the vertex transform and projection block
// ----------------------------------------------------------------------------
package tapv_pkg;

    localparam int unsigned FIELD_W    = 32;
    localparam int unsigned NUM_WORDS  = 12;
    localparam int unsigned WORD_IDX_W = 4;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_FACTOR_X = 3'd1;
    localparam logic [2:0] REG_FACTOR_Y = 3'd2;
    localparam logic [2:0] REG_CENTER_X = 3'd3;
    localparam logic [2:0] REG_CENTER_Y = 3'd4;

    typedef struct packed {
        logic                         opcode;
        logic [WORD_IDX_W-1:0]        coef_index;
        logic signed [FIELD_W-1:0]    coef_value;
        logic signed [FIELD_W-1:0]    vert_x;
        logic signed [FIELD_W-1:0]    vert_y;
        logic signed [FIELD_W-1:0]    vert_z;
        logic                         last_vertex;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0]    cam_x;
        logic signed [FIELD_W-1:0]    cam_y;
        logic signed [FIELD_W-1:0]    cam_z;
        logic signed [FIELD_W-1:0]    screen_x;
        logic signed [FIELD_W-1:0]    screen_y;
        logic signed [FIELD_W-1:0]    inv_depth;
        logic                         behind_camera;
        logic                         last_vertex_out;
    } out_item_t;

endpackage

### hw/rtl/tapv_mulq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapv_mulq
// registered fixed point multiply: floor(a*b >> FRAC_BITS), clamped to +-2^60
// ----------------------------------------------------------------------------
module tapv_mulq #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] a,
    input  logic signed [COORD_WIDTH-1:0] b,
    output logic signed [61:0]            p
);
    localparam int PW = 2 * COORD_WIDTH;
    localparam int SW = (PW > 62) ? PW : 62;

    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] shifted;
    logic signed [SW-1:0] lim_pos;
    logic signed [SW-1:0] lim_neg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    always_comb begin
        shifted = SW'(prod_reg >>> FRAC_BITS);
        lim_pos = SW'(64'sd1 <<< 60);
        lim_neg = -lim_pos;
        if (shifted > lim_pos) begin
            p = 62'(lim_pos);
        end else if (shifted < lim_neg) begin
            p = 62'(lim_neg);
        end else begin
            p = 62'(shifted);
        end
    end

endmodule

### hw/rtl/tapv_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tapv_recip
// pipelined restoring divider, one quotient bit per stage
// quotient = 2^(2*FRAC_BITS) / |z|, saturated and signed
// ----------------------------------------------------------------------------
module tapv_recip #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] z,
    output logic signed [COORD_WIDTH-1:0] inv
);
    localparam int NW = 2 * FRAC_BITS + 1;
    localparam int DW = COORD_WIDTH;
    localparam int ST = NW;

    logic [DW-1:0] den_reg  [ST+1];
    logic [DW:0]   rem_reg  [ST+1];
    logic [NW-1:0] quo_reg  [ST+1];
    logic          neg_reg  [ST+1];
    logic          zero_reg [ST+1];

    logic [DW-1:0] mag_in;
    logic [DW:0]   trial [ST];
    logic [NW-1:0] qmax;

    assign mag_in = z[DW-1] ? DW'(-z) : DW'(z);

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]  <= mag_in;
            rem_reg[0]  <= '0;
            quo_reg[0]  <= NW'(1) << (NW - 1);
            neg_reg[0]  <= z[DW-1];
            zero_reg[0] <= (z == '0);
        end
    end

    for (genvar s = 0; s < ST; s++) begin : g_div
        assign trial[s] = {rem_reg[s][DW-1:0], quo_reg[s][NW-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[s+1]  <= den_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                zero_reg[s+1] <= zero_reg[s];
                if (trial[s] >= {1'b0, den_reg[s]}) begin
                    rem_reg[s+1] <= trial[s] - {1'b0, den_reg[s]};
                    quo_reg[s+1] <= {quo_reg[s][NW-2:0], 1'b1};
                end else begin
                    rem_reg[s+1] <= trial[s];
                    quo_reg[s+1] <= {quo_reg[s][NW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        qmax = NW'({1'b0, {(DW-1){1'b1}}});
        if (zero_reg[ST]) begin
            inv = {1'b0, {(DW-1){1'b1}}};
        end else if ({1'b0, quo_reg[ST]} > {1'b0, qmax}) begin
            inv = neg_reg[ST] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            inv = neg_reg[ST] ? DW'(-quo_reg[ST]) : DW'(quo_reg[ST]);
        end
    end

endmodule

### hw/rtl/transform_and_project_vertex.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transform_and_project_vertex
// affine vertex transform, reciprocal depth and screen projection
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while the output is not stalled, set by a fully pipelined datapath
// reciprocal uses one restoring divide stage per quotient bit
// matrix loads produce no result
// reset: identity matrix, perspective mode, unit scale, zero center
// ----------------------------------------------------------------------------
module transform_and_project_vertex #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tapv_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tapv_pkg::out_item_t  m_data
);
    localparam int CW   = COORD_WIDTH;
    localparam int DIVL = 2 * FRAC_BITS + 1;
    localparam int LAT  = DIVL + 6;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE  = CW'(1) << FRAC_BITS;

    logic signed [CW-1:0] mat_reg [tapv_pkg::NUM_WORDS];
    logic                 persp_reg;
    logic signed [CW-1:0] fx_reg, fy_reg, ctrx_reg, ctry_reg;

    logic en;
    logic in_fire;
    logic vld_reg [LAT+1];
    logic last_reg [LAT+1];
    logic persp_p_reg [LAT+1];

    function automatic logic signed [CW-1:0] sat62(input logic signed [63:0] v);
        if (v > 64'(CMAX)) return CMAX;
        if (v < 64'(CMIN)) return CMIN;
        return CW'(v);
    endfunction

    // pipeline advances when output slot is free
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign in_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            persp_reg <= 1'b1;
            fx_reg    <= ONE;
            fy_reg    <= ONE;
            ctrx_reg  <= '0;
            ctry_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tapv_pkg::REG_MODE:     persp_reg <= cfg_data[0];
                tapv_pkg::REG_FACTOR_X: fx_reg    <= CW'($signed(cfg_data));
                tapv_pkg::REG_FACTOR_Y: fy_reg    <= CW'($signed(cfg_data));
                tapv_pkg::REG_CENTER_X: ctrx_reg  <= CW'($signed(cfg_data));
                tapv_pkg::REG_CENTER_Y: ctry_reg  <= CW'($signed(cfg_data));
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tapv_pkg::NUM_WORDS; i++) begin
                mat_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE : '0;
            end
        end else if (in_fire && s_data.opcode == tapv_pkg::OP_LOAD &&
                     s_data.coef_index < 4'(tapv_pkg::NUM_WORDS)) begin
            mat_reg[s_data.coef_index] <= CW'(s_data.coef_value);
        end
    end

    // stage 0: capture vertex
    logic signed [CW-1:0] v_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_fire && s_data.opcode == tapv_pkg::OP_VERTEX;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0]       <= CW'(s_data.vert_x);
            v_reg[1]       <= CW'(s_data.vert_y);
            v_reg[2]       <= CW'(s_data.vert_z);
            last_reg[0]    <= s_data.last_vertex;
            persp_p_reg[0] <= persp_reg;
        end
    end

    for (genvar k = 0; k < LAT; k++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                last_reg[k+1]    <= last_reg[k];
                persp_p_reg[k+1] <= persp_p_reg[k];
            end
        end
    end

    // stage 1: nine matrix products
    logic signed [61:0] mp [9];
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            tapv_mulq #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_mul (
                .aclk (aclk),
                .en   (en),
                .a    (mat_reg[3*i+j]),
                .b    (v_reg[j]),
                .p    (mp[3*i+j])
            );
        end
    end
    logic signed [CW-1:0] t_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                t_reg[i] <= mat_reg[9+i];
            end
        end
    end

    // stage 2: sum rows and saturate
    logic signed [CW-1:0] cam_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                cam_reg[i] <= sat62(64'(mp[3*i]) + 64'(mp[3*i+1]) + 64'(mp[3*i+2])
                                    + 64'(t_reg[i]));
            end
        end
    end

    // reciprocal depth, cam delayed alongside
    logic signed [CW-1:0] inv_w;
    tapv_recip #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_recip (
        .aclk (aclk),
        .en   (en),
        .z    (cam_reg[2]),
        .inv  (inv_w)
    );
    logic signed [CW-1:0] dx_reg [DIVL+1];
    logic signed [CW-1:0] dy_reg [DIVL+1];
    logic signed [CW-1:0] dz_reg [DIVL+1];
    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg[0] <= cam_reg[0];
            dy_reg[0] <= cam_reg[1];
            dz_reg[0] <= cam_reg[2];
            for (int k = 0; k < DIVL; k++) begin
                dx_reg[k+1] <= dx_reg[k];
                dy_reg[k+1] <= dy_reg[k];
                dz_reg[k+1] <= dz_reg[k];
            end
        end
    end
    logic signed [CW-1:0] cx, cy, cz;
    assign cx = dx_reg[DIVL];
    assign cy = dy_reg[DIVL];
    assign cz = dz_reg[DIVL];

    // stages a-b: scale by inv (perspective) or pass through
    logic signed [CW-1:0] inv_a_reg, cx_a_reg, cy_a_reg, cz_a_reg;
    logic signed [61:0] px, py;
    tapv_mulq #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_px (
        .aclk (aclk), .en (en), .a (cx), .b (inv_w), .p (px)
    );
    tapv_mulq #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_py (
        .aclk (aclk), .en (en), .a (cy), .b (inv_w), .p (py)
    );
    always_ff @(posedge aclk) begin
        if (en) begin
            inv_a_reg <= inv_w;
            cx_a_reg  <= cx;
            cy_a_reg  <= cy;
            cz_a_reg  <= cz;
        end
    end
    logic signed [CW-1:0] qx_reg, qy_reg, inv_b_reg, cx_b_reg, cy_b_reg, cz_b_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            qx_reg    <= persp_p_reg[DIVL+4] ? sat62(64'(px)) : cx_a_reg;
            qy_reg    <= persp_p_reg[DIVL+4] ? sat62(64'(py)) : cy_a_reg;
            inv_b_reg <= inv_a_reg;
            cx_b_reg  <= cx_a_reg;
            cy_b_reg  <= cy_a_reg;
            cz_b_reg  <= cz_a_reg;
        end
    end

    // stages c-d: screen scale and center
    logic signed [61:0] sxp, syp;
    tapv_mulq #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_sx (
        .aclk (aclk), .en (en), .a (qx_reg), .b (fx_reg), .p (sxp)
    );
    tapv_mulq #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_sy (
        .aclk (aclk), .en (en), .a (qy_reg), .b (fy_reg), .p (syp)
    );
    logic signed [CW-1:0] inv_c_reg, cx_c_reg, cy_c_reg, cz_c_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            inv_c_reg <= inv_b_reg;
            cx_c_reg  <= cx_b_reg;
            cy_c_reg  <= cy_b_reg;
            cz_c_reg  <= cz_b_reg;
        end
    end

    logic behind;
    assign behind = persp_p_reg[LAT] && (cz_c_reg <= 0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= vld_reg[LAT];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            m_data.cam_x           <= 32'(cx_c_reg);
            m_data.cam_y           <= 32'(cy_c_reg);
            m_data.cam_z           <= 32'(cz_c_reg);
            m_data.screen_x        <= behind ? 32'(CMIN)
                                     : 32'(sat62(64'(ctrx_reg) + 64'(sxp)));
            m_data.screen_y        <= behind ? 32'(CMIN)
                                     : 32'(sat62(64'(ctry_reg) - 64'(syp)));
            m_data.inv_depth       <= behind ? '0 : 32'(inv_c_reg);
            m_data.behind_camera   <= behind;
            m_data.last_vertex_out <= last_reg[LAT];
        end
    end

endmodule
